[src/lpim_pkg.sv]
`timescale 1ns / 1ps
// Package for the linear probe index map: table sizes, field widths, codes and types.
// No dependencies; every other file of the block but lpim_ram takes its names from here.
package lpim_pkg;

  localparam int unsigned TABLE_SIZE = 4096;
  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned TABLE_AW   = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned MAXE_W   = 13;
  localparam int unsigned MAXE_RESET = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 3'd0,
    ST_PRESENT    = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_CAP_FULL   = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_INVALID    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

endpackage

[src/lpim_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the linear probe index map.
// Depends on lpim_pkg for field widths.
interface lpim_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpim_pkg::OP_W-1:0]     operation;
  logic [lpim_pkg::KEY_W-1:0]    key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface lpim_out_if;
  logic                            valid;
  logic                            ready;
  logic [lpim_pkg::STATUS_W-1:0]   status;
  logic [lpim_pkg::SLOT_W-1:0]     slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

[src/linear_probe_index_map_top.sv]
`timescale 1ns / 1ps
// Linear probe index map, top level: configuration register, table RAM, sequencer
// and result register. Depends on lpim_pkg, lpim_if, lpim_ram and lpim_ctrl.
//
// Maps a nonzero 32-bit key to a dense slot number through a 4096-entry open
// addressing table held in one RAM of key and slot per entry, with a registered
// read. One request is worked at a time. A lookup or insert probes entries one
// after another, one read per cycle, at least one and at most 4096, before its
// result; a request with key zero or an unused operation is answered with no
// probe. A clear, and the sweep after reset, write every entry once, and no
// request is taken during the sweep; the result of a clear follows its sweep.
// max_entities may be written at any time the block is idle and applies to
// the next insert.
module linear_probe_index_map_top (
  input  logic                        clk,
  input  logic                        rst_n,
  lpim_in_if.sink                     in_chan,
  lpim_out_if.source                  out_chan,
  input  logic                        cfg_wr_en,
  input  logic [lpim_pkg::MAXE_W-1:0] cfg_wr_data
);

  logic [lpim_pkg::MAXE_W-1:0] max_entities_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [lpim_pkg::STATUS_W-1:0] out_status_r;
  logic [lpim_pkg::SLOT_W-1:0] out_slot_r;

  lpim_pkg::rsp_t              rsp;
  logic                        rsp_ack;
  logic                        ram_we;
  logic [lpim_pkg::TABLE_AW-1:0] ram_waddr;
  logic [lpim_pkg::TABLE_AW-1:0] ram_raddr;
  lpim_pkg::entry_t            ram_wdata;
  lpim_pkg::entry_t            ram_rdata;
  logic [lpim_pkg::ENTRY_W-1:0] ram_rdata_raw;

  lpim_ram #(
    .DEPTH (lpim_pkg::TABLE_SIZE),
    .WIDTH (lpim_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = lpim_pkg::entry_t'(ram_rdata_raw);

  lpim_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .max_entities (max_entities_r),
    .rsp          (rsp),
    .rsp_ack      (rsp_ack),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  assign rsp_ack = rsp.valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entities_r <= lpim_pkg::MAXE_W'(lpim_pkg::MAXE_RESET);
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_entities_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ack) begin
      out_status_r <= rsp.status;
      out_slot_r   <= rsp.slot;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.slot_index = out_slot_r;

endmodule

[src/lpim_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lpim_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/lpim_ctrl.sv]
`timescale 1ns / 1ps
// Probe sequencer: clearing sweep, linear probe over the table RAM, slot counter.
// Depends on lpim_pkg and lpim_in_if; drives the ports of lpim_ram.
module lpim_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  lpim_in_if.sink                          in_chan,
  input  logic [lpim_pkg::MAXE_W-1:0]      max_entities,
  output lpim_pkg::rsp_t                   rsp,
  input  logic                             rsp_ack,
  output logic                             ram_we,
  output logic [lpim_pkg::TABLE_AW-1:0]    ram_waddr,
  output lpim_pkg::entry_t                 ram_wdata,
  output logic [lpim_pkg::TABLE_AW-1:0]    ram_raddr,
  input  lpim_pkg::entry_t                 ram_rdata
);

  localparam logic [lpim_pkg::TABLE_AW-1:0] LastAddr =
    lpim_pkg::TABLE_AW'(lpim_pkg::TABLE_SIZE - 1);

  lpim_pkg::state_t                  state_r, state_nxt;
  logic [lpim_pkg::KEY_W-1:0]        key_r, key_nxt;
  logic                              is_ins_r, is_ins_nxt;
  logic [lpim_pkg::TABLE_AW-1:0]     chk_addr_r, chk_addr_nxt;
  logic [lpim_pkg::TABLE_AW-1:0]     cnt_r, cnt_nxt;
  logic [lpim_pkg::TABLE_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic                              clr_rsp_r, clr_rsp_nxt;
  logic [lpim_pkg::CNT_W-1:0]        slot_cnt_r, slot_cnt_nxt;
  lpim_pkg::status_t                 res_status_r, res_status_nxt;
  logic [lpim_pkg::SLOT_W-1:0]       res_slot_r, res_slot_nxt;

  logic                              accept;
  logic                              hit;
  logic                              empty;
  logic                              below_cap;
  logic                              ins_wr;
  logic [lpim_pkg::CNT_W-1:0]        limit;

  assign accept    = in_chan.valid && in_chan.ready;
  assign hit       = (ram_rdata.key == key_r);
  assign empty     = (ram_rdata.key == '0);
  assign limit     = (32'(max_entities) > lpim_pkg::SLOT_COUNT) ?
                     lpim_pkg::CNT_W'(lpim_pkg::SLOT_COUNT) :
                     lpim_pkg::CNT_W'(max_entities);
  assign below_cap = (slot_cnt_r < limit);
  assign ins_wr    = (state_r == lpim_pkg::S_PROBE) && !hit && empty && is_ins_r && below_cap;

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    is_ins_nxt     = is_ins_r;
    chk_addr_nxt   = chk_addr_r;
    cnt_nxt        = cnt_r;
    clr_addr_nxt   = clr_addr_r;
    clr_rsp_nxt    = clr_rsp_r;
    slot_cnt_nxt   = slot_cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    case (state_r)
      lpim_pkg::S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        slot_cnt_nxt = '0;
        if (clr_addr_r == LastAddr) begin
          state_nxt      = clr_rsp_r ? lpim_pkg::S_RESP : lpim_pkg::S_IDLE;
          res_status_nxt = lpim_pkg::ST_DONE;
          res_slot_nxt   = '0;
        end
      end
      lpim_pkg::S_IDLE: begin
        if (accept) begin
          key_nxt        = in_chan.key;
          is_ins_nxt     = (in_chan.operation == lpim_pkg::OP_INSERT);
          chk_addr_nxt   = in_chan.key[lpim_pkg::TABLE_AW-1:0];
          cnt_nxt        = '0;
          res_status_nxt = lpim_pkg::ST_INVALID;
          res_slot_nxt   = '0;
          if (in_chan.operation == lpim_pkg::OP_CLEAR) begin
            state_nxt    = lpim_pkg::S_CLEAR;
            clr_addr_nxt = '0;
            clr_rsp_nxt  = 1'b1;
          end else if ((in_chan.operation == lpim_pkg::OP_LOOKUP ||
                        in_chan.operation == lpim_pkg::OP_INSERT) &&
                       in_chan.key != '0) begin
            state_nxt = lpim_pkg::S_PROBE;
          end else begin
            state_nxt = lpim_pkg::S_RESP;
          end
        end
      end
      lpim_pkg::S_PROBE: begin
        chk_addr_nxt = chk_addr_r + 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (hit) begin
          state_nxt      = lpim_pkg::S_RESP;
          res_status_nxt = is_ins_r ? lpim_pkg::ST_PRESENT : lpim_pkg::ST_DONE;
          res_slot_nxt   = is_ins_r ? '0 : ram_rdata.slot;
        end else if (empty) begin
          state_nxt = lpim_pkg::S_RESP;
          if (!is_ins_r) begin
            res_status_nxt = lpim_pkg::ST_NOT_FOUND;
          end else if (!below_cap) begin
            res_status_nxt = lpim_pkg::ST_CAP_FULL;
          end else begin
            res_status_nxt = lpim_pkg::ST_DONE;
            res_slot_nxt   = lpim_pkg::SLOT_W'(slot_cnt_r);
            slot_cnt_nxt   = slot_cnt_r + 1'b1;
          end
        end else if (cnt_r == LastAddr) begin
          state_nxt      = lpim_pkg::S_RESP;
          res_status_nxt = is_ins_r ? lpim_pkg::ST_TABLE_FULL : lpim_pkg::ST_NOT_FOUND;
        end
      end
      lpim_pkg::S_RESP: begin
        clr_rsp_nxt = 1'b0;
        if (rsp_ack) begin
          state_nxt = lpim_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lpim_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready = (state_r == lpim_pkg::S_IDLE);
    ram_raddr     = (state_r == lpim_pkg::S_IDLE) ?
                    in_chan.key[lpim_pkg::TABLE_AW-1:0] : chk_addr_r + 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = chk_addr_r;
    ram_wdata     = '0;
    case (state_r)
      lpim_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      lpim_pkg::S_PROBE: begin
        ram_we         = ins_wr;
        ram_wdata.key  = key_r;
        ram_wdata.slot = lpim_pkg::SLOT_W'(slot_cnt_r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    rsp.valid  = (state_r == lpim_pkg::S_RESP);
    rsp.status = res_status_r;
    rsp.slot   = res_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lpim_pkg::S_CLEAR;
      clr_addr_r <= '0;
      clr_rsp_r  <= 1'b0;
      slot_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_rsp_r  <= clr_rsp_nxt;
      slot_cnt_r <= slot_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    is_ins_r     <= is_ins_nxt;
    chk_addr_r   <= chk_addr_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

endmodule

[src/lpim_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the linear probe index map, bound to the top level.
// Depends on lpim_pkg and linear_probe_index_map_top.
module lpim_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [lpim_pkg::OP_W-1:0]     in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lpim_pkg::STATUS_W-1:0] out_status,
  input logic [lpim_pkg::SLOT_W-1:0]   out_slot_index
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot_index))
    else $error("stalled result changed");

  // zero slot on any failure
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lpim_pkg::ST_DONE |-> out_slot_index == '0)
    else $error("nonzero slot with failing status");

  // sweep the table after reset before taking a request
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during reset sweep");

  // drop ready once a clear is taken
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == lpim_pkg::OP_CLEAR |=> !in_ready ##1 !in_ready)
    else $error("request taken during clear");

endmodule

bind linear_probe_index_map_top lpim_checker u_lpim_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_operation   (in_chan.operation),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_slot_index (out_chan.slot_index)
);

[bench/lpim_checker.sv]
`timescale 1ns / 1ps
// Response checker for the linear probe index map: watches both channels and the
// max_entities write port, predicts each response and compares. Depends on lpim_pkg, lpim_if.
module lpim_scoreboard
  import lpim_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lpim_in_if                in_mon,
  lpim_out_if               out_mon,
  input  logic              cfg_wr_en,
  input  logic [MAXE_W-1:0] cfg_wr_data,
  output int                pending,
  output int                mismatches
);

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  typedef enum int {
    PROBE_HIT,
    PROBE_EMPTY,
    PROBE_EXHAUSTED
  } probe_end_t;

  logic [KEY_W-1:0]  key_mem [TABLE_SIZE];
  logic [SLOT_W-1:0] slot_mem [TABLE_SIZE];
  logic [CNT_W-1:0]  slots_given;
  logic [MAXE_W-1:0] max_slots;
  answer_t           answers_due [$];

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void clear_table();
    for (int unsigned i = 0; i < TABLE_SIZE; i++) key_mem[i] = '0;
    slots_given = '0;
  endfunction

  function automatic probe_end_t find_entry(input logic [KEY_W-1:0] key,
                                            output int unsigned idx);
    int unsigned pos;
    for (int unsigned off = 0; off < TABLE_SIZE; off++) begin
      pos = (key + off) & (TABLE_SIZE - 1);
      if (key_mem[pos] == key) begin
        idx = pos;
        return PROBE_HIT;
      end
      if (key_mem[pos] == '0) begin
        idx = pos;
        return PROBE_EMPTY;
      end
    end
    idx = 0;
    return PROBE_EXHAUSTED;
  endfunction

  // Work out the response to one request and advance the table copy.
  function automatic answer_t map_request(input logic [OP_W-1:0] op,
                                          input logic [KEY_W-1:0] key);
    answer_t     ans;
    probe_end_t  found;
    int unsigned idx;
    int unsigned limit;
    ans.status = ST_INVALID;
    ans.slot   = '0;
    if (op == OP_CLEAR) begin
      clear_table();
      ans.status = ST_DONE;
    end else if ((op == OP_LOOKUP || op == OP_INSERT) && key != '0) begin
      found = find_entry(key, idx);
      limit = (max_slots > SLOT_COUNT) ? SLOT_COUNT : max_slots;
      if (op == OP_LOOKUP) begin
        if (found == PROBE_HIT) begin
          ans.status = ST_DONE;
          ans.slot   = slot_mem[idx];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end else if (found == PROBE_HIT) begin
        ans.status = ST_PRESENT;
      end else if (found == PROBE_EXHAUSTED) begin
        ans.status = ST_TABLE_FULL;
      end else if (slots_given >= limit) begin
        ans.status = ST_CAP_FULL;
      end else begin
        ans.slot      = slots_given[SLOT_W-1:0];
        key_mem[idx]  = key;
        slot_mem[idx] = slots_given[SLOT_W-1:0];
        slots_given   = slots_given + 1'b1;
        ans.status    = ST_DONE;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      clear_table();
      max_slots = MAXE_W'(MAXE_RESET);
      answers_due.delete();
    end else begin
      if (cfg_wr_en) max_slots = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("response with no request waiting: status %0d slot %0d",
                                    out_mon.status, out_mon.slot_index));
        end else begin
          want = answers_due.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_mon.status, want.status));
          if (out_mon.slot_index !== want.slot)
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      out_mon.slot_index, want.slot));
        end
      end
      if (in_mon.valid && in_mon.ready)
        answers_due.push_back(map_request(in_mon.operation, in_mon.key));
    end
    pending <= answers_due.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for linear_probe_index_map_top: clock, reset, request and response
// drivers, max_entities writes and the verdict. Depends on lpim_pkg, lpim_if, lpim_checker.
module tb_top;
  import lpim_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 100;
  localparam int NUM_PHASES     = 6;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [MAXE_W-1:0] cfg_wr_data;
  int                pending;
  int                mismatches;
  int                tx_idle_pct;
  int                rx_stall_pct;
  logic              hold_req;
  int                hold_left;
  int                idle_cycles;
  logic [KEY_W-1:0]  key_pool [$];

  lpim_in_if  in_chan ();
  lpim_out_if out_chan ();

  linear_probe_index_map_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lpim_scoreboard u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always #1 clk = ~clk;

  // Response side: random stalls, or a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("linear_probe_index_map_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.key       <= key;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drop the request line and hold until every response is back.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_max_entities(input logic [MAXE_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = $urandom();
    if ($urandom_range(1)) k[11:0] = 12'($urandom_range(31));
    return k;
  endfunction

  task automatic random_request();
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_request(OP_CLEAR, $urandom());
      key_pool.delete();
    end else if (pick < 6) begin
      send_request(OP_UNUSED, $urandom());
    end else if (pick < 9) begin
      send_request($urandom_range(1) ? OP_INSERT : OP_LOOKUP, '0);
    end else if (pick < 50) begin
      if (key_pool.size() > 0 && $urandom_range(3) == 0) begin
        key = key_pool[$urandom_range(key_pool.size() - 1)];
      end else begin
        key = fresh_key();
        key_pool.push_back(key);
      end
      send_request(OP_INSERT, key);
    end else begin
      if (key_pool.size() > 0 && $urandom_range(9) < 6)
        key = key_pool[$urandom_range(key_pool.size() - 1)];
      else
        key = fresh_key();
      send_request(OP_LOOKUP, key);
    end
  endtask

  initial begin
    int                tx_modes [4];
    int                rx_modes [4];
    logic [MAXE_W-1:0] max_modes [NUM_PHASES];
    tx_modes  = '{0, 67, 0, 22};
    rx_modes  = '{0, 0, 67, 22};
    max_modes = '{13'd4096, 13'd8191, 13'd0, 13'd1, 13'd60, 13'd4095};
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_chan.valid     = 1'b0;
    in_chan.operation = '0;
    in_chan.key       = '0;
    out_chan.ready    = 1'b0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    hold_req          = 1'b0;
    hold_left         = 0;
    idle_cycles       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: edge keys, wrap-around probing, every status but table full
    send_request(OP_LOOKUP, 32'h0000_0001);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h0000_0000);
    send_request(OP_UNUSED, 32'h0000_0005);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_1FFF);
    send_request(OP_LOOKUP, 32'h0000_1FFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_LOOKUP, 32'h8000_0000);
    send_request(OP_LOOKUP, 32'h4000_0000);
    write_max_entities(13'd0);
    send_request(OP_INSERT, 32'h1234_5678);
    send_request(OP_LOOKUP, 32'h0000_0001);
    write_max_entities(13'd5);
    send_request(OP_INSERT, 32'h1234_5678);
    send_request(OP_INSERT, 32'h00AB_CDEF);
    send_request(OP_LOOKUP, 32'h1234_5678);
    send_request(OP_CLEAR, 32'hDEAD_BEEF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF);

    // fill the block while the response side holds off
    write_max_entities(13'd4096);
    hold_req = 1'b1;
    repeat (20) send_request(OP_INSERT, fresh_key());
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_max_entities(max_modes[p]);
      tx_idle_pct  = tx_modes[p % 4];
      rx_stall_pct = rx_modes[p % 4];
      repeat (PHASE_ITEMS) random_request();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("linear_probe_index_map_top verification clean");
    end else begin
      $display("linear_probe_index_map_top verification failed");
    end
    $finish;
  end

endmodule
